[rtl/core/ipd_pkg.sv]
package ipd_pkg;

  localparam int unsigned InW          = 16;
  localparam int unsigned VoltW        = 15;
  localparam int unsigned DutyW        = 11;
  localparam int unsigned HalfScaleDef = 1000;

  localparam logic [VoltW-1:0] VoltLimitRst = 15'd32767;
  localparam logic [DutyW-1:0] DutyMinRst   = 11'd0;
  localparam logic [DutyW-1:0] DutyMaxRst   = 11'd2000;

  typedef enum logic [1:0] {
    RegVoltLimit = 2'd0,
    RegDutyMin   = 2'd1,
    RegDutyMax   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [InW-1:0] volt_d;
    logic signed [InW-1:0] volt_q;
    logic signed [InW-1:0] cos_u;
    logic signed [InW-1:0] sin_u;
    logic signed [InW-1:0] cos_v;
    logic signed [InW-1:0] sin_v;
    logic signed [InW-1:0] cos_w;
    logic signed [InW-1:0] sin_w;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_u;
    logic [DutyW-1:0] duty_v;
    logic [DutyW-1:0] duty_w;
  } out_item_t;

  // lim is the voltage limit with zero already mapped to one
  typedef struct packed {
    logic [VoltW-1:0] lim;
    logic [DutyW-1:0] duty_min;
    logic [DutyW-1:0] duty_max;
  } cfg_t;

  // quotient bits needed: the quotient never exceeds the half scale
  function automatic int unsigned quo_width(input int unsigned half);
    quo_width = $clog2(half + 1);
  endfunction

endpackage

[rtl/core/ipd_phase.sv]
module ipd_phase #(
  parameter int unsigned HALF_SCALE = ipd_pkg::HalfScaleDef
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [ipd_pkg::InW-1:0] volt_d_i,
  input  logic signed [ipd_pkg::InW-1:0] volt_q_i,
  input  logic signed [ipd_pkg::InW-1:0] cos_i,
  input  logic signed [ipd_pkg::InW-1:0] sin_i,
  input  ipd_pkg::cfg_t                  cfg_i,
  output logic [ipd_pkg::DutyW-1:0]      duty_o
);
  import ipd_pkg::*;

  localparam int unsigned QW   = quo_width(HALF_SCALE);
  localparam int unsigned NumW = VoltW + QW;
  localparam int unsigned DW   = QW + 1;
  localparam int unsigned CW   = (DW > DutyW) ? DW : DutyW;

  // stage 1: products
  logic signed [2*InW-1:0] pc_q, ps_q;
  // stage 2: shifted difference
  logic signed [2*InW:0]   diff;
  logic signed [17:0]      v_q;
  // stage 3: clamped magnitude and sign
  logic signed [17:0]      lim_s;
  logic [VoltW-1:0]        mag_d, mag_q;
  logic                    neg_d, neg3_q;
  // stage 4: scaled numerator
  logic [NumW-1:0]         num_q;
  logic                    neg4_q;
  // divider stages, one quotient bit each
  logic [VoltW-1:0]        rem_q [QW];
  logic [VoltW-1:0]        rem_d [QW];
  logic [QW-1:0]           sh_q  [QW];
  logic [QW-1:0]           sh_d  [QW];
  logic                    ndv_q [QW];
  logic [VoltW:0]          trial [QW];
  logic [VoltW-1:0]        rem_in [QW];
  logic [QW-1:0]           sh_in  [QW];
  // final stage
  logic [CW-1:0]           sum, lo_b, res;
  logic [DutyW-1:0]        duty_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q <= cos_i * volt_d_i;
      ps_q <= sin_i * volt_q_i;
    end
  end

  assign diff = (2*InW+1)'(pc_q) - (2*InW+1)'(ps_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= 18'(diff >>> 15);
    end
  end

  assign lim_s = signed'({3'b000, cfg_i.lim});

  always_comb begin
    if (v_q > lim_s) begin
      mag_d = cfg_i.lim;
      neg_d = 1'b0;
    end else if (v_q < -lim_s) begin
      mag_d = cfg_i.lim;
      neg_d = 1'b1;
    end else begin
      neg_d = v_q[17];
      mag_d = neg_d ? VoltW'(-v_q) : VoltW'(v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg3_q <= neg_d;
      num_q  <= NumW'(mag_q) * NumW'(HALF_SCALE);
      neg4_q <= neg3_q;
    end
  end

  // restoring division; the top part of the numerator is already below lim
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_in[j] = num_q[NumW-1:QW];
        sh_in[j]  = num_q[QW-1:0];
      end else begin
        rem_in[j] = rem_q[j-1];
        sh_in[j]  = sh_q[j-1];
      end
      trial[j] = {rem_in[j], sh_in[j][QW-1]};
      if (trial[j] >= {1'b0, cfg_i.lim}) begin
        rem_d[j] = VoltW'(trial[j] - {1'b0, cfg_i.lim});
        sh_d[j]  = {sh_in[j][QW-2:0], 1'b1};
      end else begin
        rem_d[j] = trial[j][VoltW-1:0];
        sh_d[j]  = {sh_in[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_d[j];
        sh_q[j]  <= sh_d[j];
        ndv_q[j] <= (j == 0) ? neg4_q : ndv_q[j-1];
      end
    end
  end

  // offset by half scale, then floor at duty_min and cap at duty_max
  always_comb begin
    if (ndv_q[QW-1]) begin
      sum = CW'(HALF_SCALE) - CW'(sh_q[QW-1]);
    end else begin
      sum = CW'(HALF_SCALE) + CW'(sh_q[QW-1]);
    end
    lo_b = (sum < CW'(cfg_i.duty_min)) ? CW'(cfg_i.duty_min) : sum;
    res  = (lo_b > CW'(cfg_i.duty_max)) ? CW'(cfg_i.duty_max) : lo_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      duty_q <= res[DutyW-1:0];
    end
  end

  assign duty_o = duty_q;

endmodule

[rtl/core/inverse_park_pwm_duty.sv]
// Inverse Park transform to three PWM duty counts, fully pipelined.
// Stages: products, shifted difference, clamp, scaled numerator, then
// one divider stage per quotient bit, then the output stage.
// Throughput: one item per cycle while the skid register is empty; an output skid register absorbs one stalled item.
// Reset (rst_ni low, async): pipeline and output empty, volt_limit = 32767,
// duty_min = 0, duty_max = 2000.
module inverse_park_pwm_duty #(
  parameter int unsigned HALF_SCALE = ipd_pkg::HalfScaleDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ipd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipd_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ipd_pkg::*;

  localparam int unsigned NumStages = quo_width(HALF_SCALE) + 5;

  logic [VoltW-1:0]     volt_limit_q;
  logic [DutyW-1:0]     duty_min_q, duty_max_q;
  cfg_t                 cfg;
  reg_idx_e             reg_idx;
  logic                 cfg_wr;

  logic                 adv;
  logic [NumStages-1:0] vld_q;
  logic                 exit_v, take;
  out_item_t            pipe_item;
  out_item_t            out_q, skid_q;
  logic                 out_v_q, skid_v_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_limit_q <= VoltLimitRst;
      duty_min_q   <= DutyMinRst;
      duty_max_q   <= DutyMaxRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegVoltLimit: volt_limit_q <= pwdata[VoltW-1:0];
        RegDutyMin:   duty_min_q   <= pwdata[DutyW-1:0];
        RegDutyMax:   duty_max_q   <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegVoltLimit: prdata = 32'(volt_limit_q);
      RegDutyMin:   prdata = 32'(duty_min_q);
      RegDutyMax:   prdata = 32'(duty_max_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg.lim      = (volt_limit_q == '0) ? VoltW'(1) : volt_limit_q;
  assign cfg.duty_min = duty_min_q;
  assign cfg.duty_max = duty_max_q;

  // pipeline runs whenever the skid register is free
  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  ipd_phase #(.HALF_SCALE(HALF_SCALE)) u_phase_u (
    .clk_i    (clk_i),
    .en_i     (adv),
    .volt_d_i (in_item_i.volt_d),
    .volt_q_i (in_item_i.volt_q),
    .cos_i    (in_item_i.cos_u),
    .sin_i    (in_item_i.sin_u),
    .cfg_i    (cfg),
    .duty_o   (pipe_item.duty_u)
  );

  ipd_phase #(.HALF_SCALE(HALF_SCALE)) u_phase_v (
    .clk_i    (clk_i),
    .en_i     (adv),
    .volt_d_i (in_item_i.volt_d),
    .volt_q_i (in_item_i.volt_q),
    .cos_i    (in_item_i.cos_v),
    .sin_i    (in_item_i.sin_v),
    .cfg_i    (cfg),
    .duty_o   (pipe_item.duty_v)
  );

  ipd_phase #(.HALF_SCALE(HALF_SCALE)) u_phase_w (
    .clk_i    (clk_i),
    .en_i     (adv),
    .volt_d_i (in_item_i.volt_d),
    .volt_q_i (in_item_i.volt_q),
    .cos_i    (in_item_i.cos_w),
    .sin_i    (in_item_i.sin_w),
    .cfg_i    (cfg),
    .duty_o   (pipe_item.duty_w)
  );

  // output register plus one skid entry
  assign exit_v = adv && vld_q[NumStages-1];
  assign take   = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (exit_v) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (exit_v) begin
      if (!out_v_q || take) begin
        out_q <= pipe_item;
      end else begin
        skid_q <= pipe_item;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

[dv/tb_inverse_park_pwm_duty.sv]
module tb_inverse_park_pwm_duty;
  import ipd_pkg::*;

  localparam int unsigned HalfScale   = HalfScaleDef;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseItems  = 255;
  localparam logic [1:0]  RegUnmapped = 2'd3;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // copy of the block's registers, kept in step with every write
  logic [VoltW-1:0] lim_cfg  = VoltLimitRst;
  logic [DutyW-1:0] dmin_cfg = DutyMinRst;
  logic [DutyW-1:0] dmax_cfg = DutyMaxRst;

  out_item_t   want_duty_q[$];
  out_item_t   want_duties;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic        idle_on = 1'b1;

  inverse_park_pwm_duty #(.HALF_SCALE(HalfScale)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DutyW-1:0] duty_of_phase(input logic signed [InW-1:0] d,
                                                     input logic signed [InW-1:0] q,
                                                     input logic signed [InW-1:0] c,
                                                     input logic signed [InW-1:0] s);
    longint lim;
    longint v;
    longint quo;
    longint duty;
    lim = (lim_cfg == '0) ? 64'sd1 : longint'(lim_cfg);
    v = (longint'(c) * longint'(d) - longint'(s) * longint'(q)) >>> 15;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    quo = ((v < 0) ? -v : v) * longint'(HalfScale) / lim;
    if (v < 0) quo = -quo;
    duty = quo + longint'(HalfScale);
    if (duty < longint'(dmin_cfg)) duty = longint'(dmin_cfg);
    if (duty > longint'(dmax_cfg)) duty = longint'(dmax_cfg);
    if (duty < 0) duty = 0;
    return duty[DutyW-1:0];
  endfunction

  function automatic out_item_t predict_duties(input in_item_t it);
    out_item_t r;
    r.duty_u = duty_of_phase(it.volt_d, it.volt_q, it.cos_u, it.sin_u);
    r.duty_v = duty_of_phase(it.volt_d, it.volt_q, it.cos_v, it.sin_v);
    r.duty_w = duty_of_phase(it.volt_d, it.volt_q, it.cos_w, it.sin_w);
    return r;
  endfunction

  function automatic in_item_t mk_item(input int d, input int q, input int cu, input int su,
                                       input int cv, input int sv, input int cw,
                                       input int sw);
    in_item_t it;
    it.volt_d = InW'(d);
    it.volt_q = InW'(q);
    it.cos_u  = InW'(cu);
    it.sin_u  = InW'(su);
    it.cos_v  = InW'(cv);
    it.sin_v  = InW'(sv);
    it.cos_w  = InW'(cw);
    it.sin_w  = InW'(sw);
    return it;
  endfunction

  // full-range items, as many with d/q inside the clamp, some near zero
  function automatic in_item_t rand_item();
    in_item_t it;
    int lim;
    int unsigned pick;
    lim = (lim_cfg == '0) ? 1 : int'(lim_cfg);
    pick = $urandom_range(99);
    it = {InW'($urandom), InW'($urandom), InW'($urandom), InW'($urandom),
          InW'($urandom), InW'($urandom), InW'($urandom), InW'($urandom)};
    if (pick >= 40 && pick < 80) begin
      it.volt_d = InW'(int'($urandom_range(2 * lim)) - lim);
      it.volt_q = InW'(int'($urandom_range(2 * lim)) - lim);
    end else if (pick >= 80) begin
      it = mk_item(int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                   int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                   int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                   int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4);
    end
    return it;
  endfunction

  task automatic send_sample(input in_item_t it);
    if (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want_duty_q.push_back(predict_duties(it));
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (want_duty_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegVoltLimit: lim_cfg  = val[VoltW-1:0];
      RegDutyMin:   dmin_cfg = val[DutyW-1:0];
      RegDutyMax:   dmax_cfg = val[DutyW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input int unsigned lim, input int unsigned dmin,
                            input int unsigned dmax);
    settle_pipeline();
    cfg_write(RegVoltLimit, lim);
    cfg_write(RegDutyMin, dmin);
    cfg_write(RegDutyMax, dmax);
  endtask

  task automatic test_field_extremes();
    send_sample(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(mk_item(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0));
    send_sample(mk_item(32767, -32768, 32767, 32767, -32768, -32768, 1, -1));
    // floor of a tiny negative product gives -1
    send_sample(mk_item(1, 1, 1, 0, 0, 1, -1, -1));
    send_sample(mk_item(16384, -8192, 23170, 23170, -28378, 16384, 0, -32768));
  endtask

  task automatic test_zero_limit();
    set_limits(0, 0, 2000);
    send_sample(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk_item(1, 1, 1, 0, 0, 1, -1, -1));
    send_sample(mk_item(32767, 0, 32767, 0, -32768, 0, 2, 0));
    set_limits(1, 0, 2000);
    send_sample(mk_item(2, 0, 32767, 0, -32768, 0, 0, 32767));
    send_sample(mk_item(-5, 5, 16384, 16384, -16384, 16384, 0, 0));
  endtask

  task automatic test_bound_conflict();
    set_limits(32767, 1500, 500);
    send_sample(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk_item(32767, 32767, 32767, -32768, -32768, 32767, 100, 100));
    set_limits(32767, 2000, 2000);
    send_sample(mk_item(-32768, 0, 32767, 0, 0, 0, 0, 0));
  endtask

  task automatic test_wide_duty_bounds();
    set_limits(32767, 0, 2047);
    send_sample(mk_item(32767, -32768, 32767, 32767, -32768, -32768, 0, 0));
    set_limits(100, 2047, 2047);
    send_sample(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_unmapped_write();
    set_limits(32767, 0, 2000);
    cfg_write(RegUnmapped, 32'd5);
    send_sample(mk_item(20000, -20000, 30000, 10000, -30000, -10000, 5, 5));
    send_sample(mk_item(-1, 1, 1, 1, -1, -1, 32767, -32768));
  endtask

  task automatic test_random_stream();
    int unsigned lim;
    int unsigned dmin;
    int unsigned dmax;
    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(3))
        0: lim = $urandom_range(1, 64);
        1: lim = 32767;
        2: lim = $urandom_range(16384, 32767);
        default: lim = $urandom_range(1, 32767);
      endcase
      dmin = ($urandom_range(3) == 0) ? $urandom_range(2000) : 0;
      dmax = ($urandom_range(3) == 0) ? $urandom_range(2000) : 2000;
      if (p == 0) begin
        lim = 32767; dmin = 0; dmax = 2000;
      end else if (p == 1) begin
        lim = 1; dmin = 0; dmax = 2047;
      end
      set_limits(lim, dmin, dmax);
      // one phase runs flat out on both sides
      idle_on <= (p != 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 3 && n == PhaseItems / 2) settle_pipeline();
        send_sample(rand_item());
      end
    end
    idle_on <= 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (want_duty_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("result with no item pending: %p", out_item);
      end else begin
        want_duties = want_duty_q.pop_front();
        check_field("duty_u", want_duties.duty_u, out_item.duty_u);
        check_field("duty_v", want_duties.duty_v, out_item.duty_v);
        check_field("duty_w", want_duties.duty_w, out_item.duty_w);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_zero_limit();
    test_bound_conflict();
    test_wide_duty_bounds();
    test_unmapped_write();
    test_random_stream();
    settle_pipeline();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0 && want_duty_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ipd_pkg.sv
rtl/core/ipd_phase.sv
rtl/core/inverse_park_pwm_duty.sv
dv/tb_inverse_park_pwm_duty.sv
